/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is ignored while reset is high.
`define ASSERT_CLK_RST(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("assertion failed: label");

// Concurrent assertion that stays live through reset.
`define ASSERT_CLK(label, clock, prop) \
  label: assert property (@(posedge clock) prop) \
    else $error("assertion failed: label");

`endif

/* hdl/uvc_pkg.sv */
// Shared types and constants of the unreferenced vertex compactor.
package uvc_pkg;

  // Fixed field widths
  localparam int IDX_W = 16;   // index_value
  localparam int NUM_W = 12;   // new_index
  localparam int CNT_W = 13;   // vertex_count register
  localparam int CMP_W = 17;   // wide enough for any index, count or cursor compare

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_MARK  = 2'd1,
    OP_NEXT  = 2'd2,
    OP_REMAP = 2'd3
  } uvc_op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } uvc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic clear_step;  // write one zero of the mark sweep
    logic commit;      // finish the item: memory writes, counters, output load
  } uvc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep is at the last mark entry
    logic out_free;    // output register can take a result this cycle
  } uvc_sts_t;

endpackage

/* hdl/uvc_ctrl.sv */
// Controller state machine: mark sweep, accept and commit sequencing.
module uvc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  uvc_pkg::uvc_op_t  in_op,
  output logic              in_ready,
  input  uvc_pkg::uvc_sts_t sts,
  output uvc_pkg::uvc_cmd_t cmd
);
  import uvc_pkg::*;

  uvc_state_t state, state_next;

  // State register; reset starts the mark sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = (in_op == OP_START) ? ST_CLEAR : ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.clear_step = 1'b0;
    cmd.commit     = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LOOKUP: cmd.commit = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* hdl/uvc_datapath.sv */
// Datapath: mark and remap memories, counters, range checks, output register.
module uvc_datapath #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  uvc_pkg::uvc_cmd_t           cmd,
  output uvc_pkg::uvc_sts_t           sts,
  input  uvc_pkg::uvc_op_t            in_op,
  input  logic [uvc_pkg::IDX_W-1:0]   in_idx,
  input  logic                        cfg_wr_en,
  input  logic [uvc_pkg::CNT_W-1:0]   cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kept,
  output logic [uvc_pkg::NUM_W-1:0]   out_num,
  output logic                        out_fault
);
  import uvc_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CUR_W = AW + 1;
  localparam logic [CMP_W-1:0] MAX_C  = CMP_W'(MAX_VERTICES);
  localparam logic [CUR_W-1:0] LAST_A = CUR_W'(MAX_VERTICES - 1);

  // Memories
  logic             marks [MAX_VERTICES];
  logic [NUM_W-1:0] remap [MAX_VERTICES];

  // Registers
  logic [CNT_W-1:0] vcount;
  logic [CUR_W-1:0] cursor;
  logic [CUR_W-1:0] next_num;
  logic [CUR_W-1:0] clr_addr;
  uvc_op_t          cur_op;
  logic [AW-1:0]    cur_addr;
  logic             idx_ok;
  logic             cur_ok;
  logic             mark_rd;
  logic [NUM_W-1:0] remap_rd;

  logic [CMP_W-1:0] count_c;
  logic [AW-1:0]    rd_addr;
  logic             res_kept;
  logic [NUM_W-1:0] res_num;
  logic             res_fault;
  logic             mark_we;
  logic             remap_we;
  logic             walk_step;
  logic [NUM_W-1:0] num_now;

  // Count in effect, saturated to the store depth
  assign count_c = (CMP_W'(vcount) > MAX_C) ? MAX_C : CMP_W'(vcount);
  assign rd_addr = (in_op == OP_NEXT) ? cursor[AW-1:0] : in_idx[AW-1:0];
  assign num_now = NUM_W'(next_num);

  assign sts.clear_last = (clr_addr == LAST_A);
  assign sts.out_free   = !out_valid || out_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else if (cfg_wr_en) begin
      vcount <= cfg_wr_data;
    end
  end

  // Item capture with range checks taken against the current count
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_op   <= in_op;
      cur_addr <= rd_addr;
      idx_ok   <= CMP_W'(in_idx) < count_c;
      cur_ok   <= CMP_W'(cursor) < count_c;
    end
  end

  // Result of the item from the registered memory reads
  always_comb begin
    res_kept  = 1'b0;
    res_num   = '0;
    res_fault = 1'b0;
    mark_we   = 1'b0;
    remap_we  = 1'b0;
    walk_step = 1'b0;
    unique case (cur_op)
      OP_MARK: begin
        res_fault = !idx_ok;
        mark_we   = idx_ok;
      end
      OP_NEXT: begin
        if (cur_ok) begin
          walk_step = 1'b1;
          res_kept  = mark_rd;
          remap_we  = mark_rd;
          res_num   = mark_rd ? num_now : '0;
        end else begin
          res_fault = 1'b1;
        end
      end
      OP_REMAP: begin
        if (idx_ok && mark_rd) res_num = remap_rd;
        else                   res_fault = 1'b1;
      end
      default: ;
    endcase
  end

  // Mark store: sweep writes zeros, mark items set a bit
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      marks[clr_addr[AW-1:0]] <= 1'b0;
    end else if (cmd.commit && mark_we) begin
      marks[cur_addr] <= 1'b1;
    end
    if (cmd.accept) begin
      mark_rd <= marks[rd_addr];
    end
  end

  // Remap table
  always_ff @(posedge clk) begin
    if (cmd.commit && remap_we) begin
      remap[cur_addr] <= res_num;
    end
    if (cmd.accept) begin
      remap_rd <= remap[rd_addr];
    end
  end

  // Counters and sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      next_num <= '0;
      clr_addr <= '0;
    end else if (cmd.accept && in_op == OP_START) begin
      cursor   <= '0;
      next_num <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear_step) clr_addr <= clr_addr + CUR_W'(1);
      if (cmd.commit && walk_step) begin
        cursor <= cursor + CUR_W'(1);
        if (remap_we) next_num <= next_num + CUR_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_kept  <= res_kept;
      out_num   <= res_num;
      out_fault <= res_fault;
    end
  end

endmodule

/* hdl/unreferenced_vertex_compactor.sv */
// Top level of the unreferenced vertex compactor.
// Renumbers the vertices of one mesh part densely. After reset and after each
// start beat the block sweeps the mark store, one entry a cycle, over all
// MAX_VERTICES entries with s_tready low; configuration writes are taken
// throughout. For a mark, next-vertex or remap beat the accept cycle reads the
// mark and remap memories at the index or cursor; in the lookup state, once
// the output register is free, the block uses the registered read data, does
// the memory write and loads the output register. s_tready stays low until
// that commit. A result waiting in the output register does not block the
// next accept. Start beats give no result. Reading the remap entry of a
// vertex that was marked but not yet walked returns an unspecified number.
module unreferenced_vertex_compactor #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  // slave side
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,      // [15:0] index_value
  input  logic [1:0]                s_tuser,      // [1:0] opcode
  // master side
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,      // [11:0] new_index, [15:12] zero
  output logic [1:0]                m_tuser,      // [0] is_kept, [1] fault
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [uvc_pkg::CNT_W-1:0] cfg_wr_data   // vertex_count
);
  import uvc_pkg::*;

  uvc_cmd_t         cmd;
  uvc_sts_t         sts;
  uvc_op_t          in_op;
  logic             out_kept;
  logic             out_fault;
  logic [NUM_W-1:0] out_num;

  assign in_op = uvc_op_t'(s_tuser);

  uvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (in_op),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uvc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_op),
    .in_idx      (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kept    (out_kept),
    .out_num     (out_num),
    .out_fault   (out_fault)
  );

  assign m_tdata = {(16 - NUM_W)'(0), out_num};
  assign m_tuser = {out_fault, out_kept};

endmodule

/* hdl/uvc_checker.sv */
// Port-level checker of the unreferenced vertex compactor and its bind.
`include "assert_macros.svh"

module uvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import uvc_pkg::*;

  // Stalled result beat holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // A faulted result carries no number and is never kept
  `ASSERT_CLK_RST(a_fault_clean, clk, rst, m_tvalid && m_tuser[1] |-> m_tdata[11:0] == 12'd0 && !m_tuser[0])
  // Padding bits stay zero
  `ASSERT_CLK_RST(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[15:12] == 4'd0)
  // A start beat opens the mark sweep, no accept in the next cycle
  `ASSERT_CLK_RST(a_start_sweep, clk, rst, s_tvalid && s_tready && s_tuser == OP_START |=> !s_tready)
  // Reset opens the mark sweep
  `ASSERT_CLK(a_reset_sweep, clk, rst |=> !s_tready && !m_tvalid)

endmodule

bind unreferenced_vertex_compactor uvc_checker u_uvc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
